[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ILR_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// expression must never be true outside reset
`define ILR_NEVER(lbl, clk_s, rst_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) else $error(msg);

`else

`define ILR_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define ILR_NEVER(lbl, clk_s, rst_s, expr, msg)

`endif

`endif

[rtl/ilr_pkg.sv]
// ----------------------------------------------------------------------------
// ilr_pkg
// Shared constants, types and helpers of the regression unit.
// ----------------------------------------------------------------------------
package ilr_pkg;

    localparam int COUNT_BITS = 24;
    localparam int MEAN_W     = 48;
    localparam int DEV_W      = 49;
    localparam int SPR_W      = 64;
    localparam int PROD_W     = 128;
    localparam int STEP_W     = 7;

    localparam logic [STEP_W-1:0] MEAN_DIV_STEPS  = 7'd49;
    localparam logic [STEP_W-1:0] SLOPE_DIV_STEPS = 7'd94;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] r;
        r = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        return r;
    endfunction

    function automatic logic [63:0] mag49(input logic signed [DEV_W-1:0] v);
        logic [DEV_W-1:0] r;
        r = v[DEV_W-1] ? (DEV_W'(0) - DEV_W'(v)) : DEV_W'(v);
        return {{(64-DEV_W){1'b0}}, r};
    endfunction

    function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            r = s[63:0];
        return r;
    endfunction

    // (|a|*|b|) >> 24 with sign, truncated toward zero, saturated to 64 bits
    function automatic logic signed [63:0] spread_term(input logic [PROD_W-1:0] p,
                                                       input logic neg);
        logic        over;
        logic [63:0] t;
        logic signed [63:0] r;
        over = |p[127:87];
        t    = {1'b0, p[86:24]};
        if (neg)
            r = over ? {1'b1, 63'd0} : -$signed(t);
        else
            r = over ? {1'b0, {63{1'b1}}} : $signed(t);
        return r;
    endfunction

endpackage

[rtl/ilr_mul.sv]
// ----------------------------------------------------------------------------
// ilr_mul
// 64x64 unsigned multiplier built from one 32x32 multiplier over four passes.
// ----------------------------------------------------------------------------
module ilr_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [63:0]                 a,
    input  logic [63:0]                 b,
    output logic                        done,
    output logic [ilr_pkg::PROD_W-1:0]  prod
);

    logic [63:0]                 a_reg;
    logic [63:0]                 b_reg;
    logic [63:0]                 pp_reg;
    logic [1:0]                  psh_reg;
    logic [2:0]                  phase_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [ilr_pkg::PROD_W-1:0]  acc_reg;
    logic [31:0]                 a_part;
    logic [31:0]                 b_part;
    logic [ilr_pkg::PROD_W-1:0]  pp_shifted;

    assign a_part     = phase_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign b_part     = phase_reg[1] ? b_reg[63:32] : b_reg[31:0];
    assign pp_shifted = {64'd0, pp_reg} << {psh_reg, 5'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 3'd0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            phase_reg <= 3'd0;
        end
        else if (busy_reg)
        begin
            phase_reg <= phase_reg + 3'd1;
            if (phase_reg == 3'd4)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (phase_reg != 3'd4)
            begin
                pp_reg  <= a_part * b_part;
                psh_reg <= {1'b0, phase_reg[0]} + {1'b0, phase_reg[1]};
            end
            if (phase_reg != 3'd0)
                acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[rtl/ilr_div.sv]
// ----------------------------------------------------------------------------
// ilr_div
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned; after N steps the low N bits of the quotient register hold
// the quotient.
// ----------------------------------------------------------------------------
module ilr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ilr_pkg::div_req_t           req,
    input  logic [ilr_pkg::PROD_W-1:0]  dividend,
    input  logic [63:0]                 divisor,
    output logic                        done,
    output logic [ilr_pkg::PROD_W-1:0]  quotient
);

    logic [63:0]                    rem_reg;
    logic [ilr_pkg::PROD_W-1:0]     dq_reg;
    logic [63:0]                    div_reg;
    logic [ilr_pkg::STEP_W-1:0]     cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [64:0]                    shifted;
    logic [64:0]                    diff;
    logic                           ge;

    assign shifted = {rem_reg, dq_reg[ilr_pkg::PROD_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == ilr_pkg::STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[63:0] : shifted[63:0];
            dq_reg  <= {dq_reg[ilr_pkg::PROD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

[rtl/incremental_linear_regression_unit.sv]
// ----------------------------------------------------------------------------
// incremental_linear_regression_unit
// Online least-squares fit of a local clock against a reference clock.
//
// Input stream (s_*): tuser = kind (1 clears the fit, 0 adds a pair);
// tdata = ref_time, local_time, both signed Q20.20.
// Output stream (m_*): one transaction per input transaction, carrying
// fit_valid, degenerate, slope (Q3.30), intercept (Q20.20), R-squared
// (Q1.16) and the sample count.
// A pair passes through two 49-step mean divisions and a 94-step slope
// division in a one-bit-per-cycle divider, at most six 64x64 products in
// a four-pass 32x32 multiplier, and a 16-step R-squared loop. A degenerate
// fit skips the slope division, the offset product and the R-squared steps;
// a clear or a first sample goes straight to the result. The next
// transaction can be accepted in the cycle after the result is loaded.
// s_tready is high only while the sequencer is idle; one result can wait in
// the output register while the next transaction is taken, and a finished
// result stalls the sequencer until the output register is free.
// Reset clears all regression state and drops m_tvalid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module incremental_linear_regression_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // ref_time[39:0], local_time[79:40]
    input  logic [0:0]   s_tuser,   // kind[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // fit_scale[32:0], fit_offset[72:33],
                                    // fit_r_squared[89:73], samples_held[113:90]
    output logic [1:0]   m_tuser    // fit_valid[0], degenerate[1]
);

    localparam int CB = ilr_pkg::COUNT_BITS;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_MX_GO     = 5'd1;
    localparam logic [4:0] ST_MX_WAIT   = 5'd2;
    localparam logic [4:0] ST_MY_GO     = 5'd3;
    localparam logic [4:0] ST_MY_WAIT   = 5'd4;
    localparam logic [4:0] ST_SM_GO     = 5'd5;
    localparam logic [4:0] ST_SM_WAIT   = 5'd6;
    localparam logic [4:0] ST_SS_GO     = 5'd7;
    localparam logic [4:0] ST_SS_WAIT   = 5'd8;
    localparam logic [4:0] ST_CO_GO     = 5'd9;
    localparam logic [4:0] ST_CO_WAIT   = 5'd10;
    localparam logic [4:0] ST_FIT       = 5'd11;
    localparam logic [4:0] ST_SLOPE     = 5'd12;
    localparam logic [4:0] ST_OFF_GO    = 5'd13;
    localparam logic [4:0] ST_OFF_WAIT  = 5'd14;
    localparam logic [4:0] ST_OFFSET    = 5'd15;
    localparam logic [4:0] ST_R2N_GO    = 5'd16;
    localparam logic [4:0] ST_R2N_WAIT  = 5'd17;
    localparam logic [4:0] ST_R2D_GO    = 5'd18;
    localparam logic [4:0] ST_R2D_WAIT  = 5'd19;
    localparam logic [4:0] ST_R2_CMP    = 5'd20;
    localparam logic [4:0] ST_R2_LOOP   = 5'd21;
    localparam logic [4:0] ST_DONE      = 5'd22;

    localparam logic [16:0] R2_ONE     = 17'd65536;
    localparam logic [32:0] SCALE_ONE  = 33'sd1 << 30;
    localparam logic [32:0] SCALE_MAX  = 33'h0_FFFF_FFFF;
    localparam logic [32:0] SCALE_MIN  = 33'h1_0000_0000;
    localparam logic [23:0] HELD_MAX   = 24'hFF_FFFF;

    logic [4:0]                         state_reg;
    logic [CB-1:0]                      cnt_reg;
    logic signed [ilr_pkg::MEAN_W-1:0]  mm_reg;
    logic signed [ilr_pkg::MEAN_W-1:0]  ms_reg;
    logic signed [63:0]                 sm_reg;
    logic signed [63:0]                 ss_reg;
    logic signed [63:0]                 co_reg;
    logic signed [ilr_pkg::MEAN_W-1:0]  x_reg;
    logic signed [ilr_pkg::MEAN_W-1:0]  y_reg;
    logic signed [ilr_pkg::DEV_W-1:0]   dx_reg;
    logic signed [ilr_pkg::DEV_W-1:0]   dy_reg;
    logic signed [63:0]                 d_reg;
    logic [32:0]                        scale_reg;
    logic [39:0]                        offset_reg;
    logic [16:0]                        r2_reg;
    logic                               valid_reg;
    logic                               degen_reg;
    logic [127:0]                       num_reg;
    logic [127:0]                       den_reg;
    logic [3:0]                         k_reg;

    logic                               m_tvalid_reg;
    logic [119:0]                       m_tdata_reg;
    logic [1:0]                         m_tuser_reg;

    logic                               mul_start;
    logic [63:0]                        mul_a;
    logic [63:0]                        mul_b;
    logic                               mul_done;
    logic [127:0]                       mul_prod;
    ilr_pkg::div_req_t                  div_req;
    logic [127:0]                       div_dividend;
    logic                               div_done;
    logic [127:0]                       div_quot;

    logic                               s_accept;
    logic [CB-1:0]                      cnt_next;
    logic signed [ilr_pkg::MEAN_W-1:0]  x_in;
    logic signed [ilr_pkg::MEAN_W-1:0]  y_in;
    logic signed [ilr_pkg::DEV_W-1:0]   ex;
    logic signed [ilr_pkg::DEV_W-1:0]   ey;
    logic [63:0]                        mag_dx;
    logic [63:0]                        mag_dy;
    logic [ilr_pkg::DEV_W-1:0]          qmean;
    logic [93:0]                        qslope;
    logic [32:0]                        scale_sat;
    logic signed [63:0]                 off_prod;
    logic signed [63:0]                 d_trunc;
    logic [39:0]                        off_clamped;
    logic [127:0]                       num_sh;
    logic                               r2_ge;
    logic                               r2_zero;
    logic [CB:0]                        cnt_ext;
    logic [23:0]                        held;
    logic                               out_free;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign x_in = {s_tdata[39:0], 8'd0};
    assign y_in = {s_tdata[79:40], 8'd0};
    assign cnt_next = (cnt_reg != {CB{1'b1}}) ? cnt_reg + 1'b1 : cnt_reg;

    assign ex = {x_reg[ilr_pkg::MEAN_W-1], x_reg} - {mm_reg[ilr_pkg::MEAN_W-1], mm_reg};
    assign ey = {y_reg[ilr_pkg::MEAN_W-1], y_reg} - {ms_reg[ilr_pkg::MEAN_W-1], ms_reg};

    assign mag_dx = ilr_pkg::mag49(dx_reg);
    assign mag_dy = ilr_pkg::mag49(dy_reg);

    assign qmean  = div_quot[ilr_pkg::DEV_W-1:0];
    assign qslope = div_quot[93:0];

    // slope saturates to Q3.30 range; the sign comes from co / spread_master
    always_comb
    begin
        if (co_reg[63] != sm_reg[63])
            scale_sat = (qslope > 94'h1_0000_0000) ? SCALE_MIN : (33'd0 - qslope[32:0]);
        else
            scale_sat = (qslope > 94'h0_FFFF_FFFF) ? SCALE_MAX : qslope[32:0];
    end

    assign off_prod = (scale_reg[32] != mm_reg[ilr_pkg::MEAN_W-1])
                    ? -$signed({1'b0, mul_prod[92:30]})
                    : $signed({1'b0, mul_prod[92:30]});

    // divide by 256 toward zero, then clamp to 40 bits
    always_comb
    begin
        d_trunc = d_reg[63] ? ((d_reg + 64'sd255) >>> 8) : (d_reg >>> 8);
        if (d_trunc > 64'sh7F_FFFF_FFFF)
            off_clamped = 40'h7F_FFFF_FFFF;
        else if (d_trunc < -64'sh80_0000_0000)
            off_clamped = 40'h80_0000_0000;
        else
            off_clamped = d_trunc[39:0];
    end

    assign num_sh  = {num_reg[126:0], 1'b0};
    assign r2_ge   = num_sh >= den_reg;
    assign r2_zero = (sm_reg == 64'sd0) || (ss_reg == 64'sd0) || (sm_reg[63] != ss_reg[63]);

    assign cnt_ext = {1'b0, cnt_reg};
    assign held    = (cnt_ext > (CB+1)'(HELD_MAX)) ? HELD_MAX : cnt_ext[23:0];

    // operand selection for the shared multiplier and divider
    always_comb
    begin
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_req      = '0;
        div_dividend = '0;
        case (state_reg)
            ST_MX_GO:
            begin
                div_req.start = 1'b1;
                div_req.steps = ilr_pkg::MEAN_DIV_STEPS;
                div_dividend  = {mag_dx[ilr_pkg::DEV_W-1:0],
                                 {(128-ilr_pkg::DEV_W){1'b0}}};
            end
            ST_MY_GO:
            begin
                div_req.start = 1'b1;
                div_req.steps = ilr_pkg::MEAN_DIV_STEPS;
                div_dividend  = {mag_dy[ilr_pkg::DEV_W-1:0],
                                 {(128-ilr_pkg::DEV_W){1'b0}}};
            end
            ST_FIT:
            begin
                div_req.start = (cnt_reg >= CB'(2)) && (sm_reg != 64'sd0);
                div_req.steps = ilr_pkg::SLOPE_DIV_STEPS;
                div_dividend  = {ilr_pkg::mag64(co_reg), 64'd0};
            end
            ST_SM_GO:
            begin
                mul_start = 1'b1;
                mul_a     = mag_dx;
                mul_b     = ilr_pkg::mag49(ex);
            end
            ST_SS_GO:
            begin
                mul_start = 1'b1;
                mul_a     = mag_dy;
                mul_b     = ilr_pkg::mag49(ey);
            end
            ST_CO_GO:
            begin
                mul_start = 1'b1;
                mul_a     = mag_dx;
                mul_b     = ilr_pkg::mag49(ey);
            end
            ST_OFF_GO:
            begin
                mul_start = 1'b1;
                mul_a     = ilr_pkg::mag64({{31{scale_reg[32]}}, scale_reg});
                mul_b     = ilr_pkg::mag64({{16{mm_reg[ilr_pkg::MEAN_W-1]}}, mm_reg});
            end
            ST_R2N_GO:
            begin
                mul_start = 1'b1;
                mul_a     = ilr_pkg::mag64(co_reg);
                mul_b     = ilr_pkg::mag64(co_reg);
            end
            ST_R2D_GO:
            begin
                mul_start = 1'b1;
                mul_a     = ilr_pkg::mag64(sm_reg);
                mul_b     = ilr_pkg::mag64(ss_reg);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    ilr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ilr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  ({{(64-CB){1'b0}}, cnt_reg} & {64{state_reg != ST_FIT}}
                   | ilr_pkg::mag64(sm_reg) & {64{state_reg == ST_FIT}}),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            mm_reg       <= '0;
            ms_reg       <= '0;
            sm_reg       <= '0;
            ss_reg       <= '0;
            co_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // a result loaded in ST_DONE takes precedence over the drain
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        if (s_tuser[0])
                        begin
                            cnt_reg   <= '0;
                            mm_reg    <= '0;
                            ms_reg    <= '0;
                            sm_reg    <= '0;
                            ss_reg    <= '0;
                            co_reg    <= '0;
                            state_reg <= ST_FIT;
                        end
                        else
                        begin
                            cnt_reg <= cnt_next;
                            x_reg   <= x_in;
                            y_reg   <= y_in;
                            if (cnt_next == CB'(1))
                            begin
                                mm_reg    <= x_in;
                                ms_reg    <= y_in;
                                sm_reg    <= '0;
                                ss_reg    <= '0;
                                co_reg    <= '0;
                                state_reg <= ST_FIT;
                            end
                            else
                            begin
                                dx_reg    <= {x_in[ilr_pkg::MEAN_W-1], x_in}
                                           - {mm_reg[ilr_pkg::MEAN_W-1], mm_reg};
                                dy_reg    <= {y_in[ilr_pkg::MEAN_W-1], y_in}
                                           - {ms_reg[ilr_pkg::MEAN_W-1], ms_reg};
                                state_reg <= ST_MX_GO;
                            end
                        end
                    end
                end
                ST_MX_GO:   state_reg <= ST_MX_WAIT;
                ST_MX_WAIT:
                begin
                    if (div_done)
                    begin
                        mm_reg    <= dx_reg[ilr_pkg::DEV_W-1]
                                   ? mm_reg - qmean[ilr_pkg::MEAN_W-1:0]
                                   : mm_reg + qmean[ilr_pkg::MEAN_W-1:0];
                        state_reg <= ST_MY_GO;
                    end
                end
                ST_MY_GO:   state_reg <= ST_MY_WAIT;
                ST_MY_WAIT:
                begin
                    if (div_done)
                    begin
                        ms_reg    <= dy_reg[ilr_pkg::DEV_W-1]
                                   ? ms_reg - qmean[ilr_pkg::MEAN_W-1:0]
                                   : ms_reg + qmean[ilr_pkg::MEAN_W-1:0];
                        state_reg <= ST_SM_GO;
                    end
                end
                ST_SM_GO:   state_reg <= ST_SM_WAIT;
                ST_SM_WAIT:
                begin
                    if (mul_done)
                    begin
                        sm_reg    <= ilr_pkg::add_sat64(sm_reg, ilr_pkg::spread_term(mul_prod,
                                         dx_reg[ilr_pkg::DEV_W-1] != ex[ilr_pkg::DEV_W-1]));
                        state_reg <= ST_SS_GO;
                    end
                end
                ST_SS_GO:   state_reg <= ST_SS_WAIT;
                ST_SS_WAIT:
                begin
                    if (mul_done)
                    begin
                        ss_reg    <= ilr_pkg::add_sat64(ss_reg, ilr_pkg::spread_term(mul_prod,
                                         dy_reg[ilr_pkg::DEV_W-1] != ey[ilr_pkg::DEV_W-1]));
                        state_reg <= ST_CO_GO;
                    end
                end
                ST_CO_GO:   state_reg <= ST_CO_WAIT;
                ST_CO_WAIT:
                begin
                    if (mul_done)
                    begin
                        co_reg    <= ilr_pkg::add_sat64(co_reg, ilr_pkg::spread_term(mul_prod,
                                         dx_reg[ilr_pkg::DEV_W-1] != ey[ilr_pkg::DEV_W-1]));
                        state_reg <= ST_FIT;
                    end
                end
                ST_FIT:
                begin
                    degen_reg <= 1'b0;
                    if (cnt_reg < CB'(2))
                    begin
                        valid_reg  <= 1'b0;
                        scale_reg  <= '0;
                        offset_reg <= '0;
                        r2_reg     <= '0;
                        state_reg  <= ST_DONE;
                    end
                    else if (sm_reg == 64'sd0)
                    begin
                        valid_reg <= 1'b1;
                        degen_reg <= 1'b1;
                        scale_reg <= SCALE_ONE;
                        d_reg     <= 64'(ms_reg) - 64'(mm_reg);
                        state_reg <= ST_OFFSET;
                    end
                    else
                    begin
                        valid_reg <= 1'b1;
                        state_reg <= ST_SLOPE;
                    end
                end
                ST_SLOPE:
                begin
                    if (div_done)
                    begin
                        scale_reg <= scale_sat;
                        state_reg <= ST_OFF_GO;
                    end
                end
                ST_OFF_GO:  state_reg <= ST_OFF_WAIT;
                ST_OFF_WAIT:
                begin
                    if (mul_done)
                    begin
                        d_reg     <= 64'(ms_reg) - off_prod;
                        state_reg <= ST_OFFSET;
                    end
                end
                ST_OFFSET:
                begin
                    offset_reg <= off_clamped;
                    r2_reg     <= '0;
                    state_reg  <= r2_zero ? ST_DONE : ST_R2N_GO;
                end
                ST_R2N_GO:  state_reg <= ST_R2N_WAIT;
                ST_R2N_WAIT:
                begin
                    if (mul_done)
                    begin
                        num_reg   <= mul_prod;
                        state_reg <= ST_R2D_GO;
                    end
                end
                ST_R2D_GO:  state_reg <= ST_R2D_WAIT;
                ST_R2D_WAIT:
                begin
                    if (mul_done)
                    begin
                        den_reg   <= mul_prod;
                        state_reg <= ST_R2_CMP;
                    end
                end
                ST_R2_CMP:
                begin
                    k_reg <= '0;
                    if (num_reg >= den_reg)
                    begin
                        r2_reg    <= R2_ONE;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_R2_LOOP;
                    end
                end
                ST_R2_LOOP:
                begin
                    num_reg <= r2_ge ? num_sh - den_reg : num_sh;
                    r2_reg  <= {r2_reg[15:0], r2_ge};
                    k_reg   <= k_reg + 1'b1;
                    if (k_reg == 4'd15)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, held, r2_reg, offset_reg, scale_reg};
                        m_tuser_reg  <= {degen_reg, valid_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ILR_ASSERT(a_one_at_a_time, clk, rst_n, s_accept |=> !s_tready,
                "input accepted while a transaction is in progress")
    `ILR_ASSERT(a_r2_range, clk, rst_n, m_tvalid |-> (m_tdata[89:73] <= R2_ONE),
                "R-squared above one")
    `ILR_ASSERT(a_invalid_zero, clk, rst_n,
                (m_tvalid && !m_tuser[0]) |-> (m_tdata[89:0] == 90'd0 && !m_tuser[1]),
                "invalid fit carries nonzero fields")
    `ILR_ASSERT(a_degen_scale, clk, rst_n,
                (m_tvalid && m_tuser[1]) |-> (m_tdata[32:0] == SCALE_ONE && m_tuser[0]),
                "degenerate fit without unit slope")

endmodule
